// ===== rtl/core/yrtp_pkg.sv =====
// ============================================================================
// yrtp_pkg - shared types and constants for the YUYV luma ramp generator
// ----------------------------------------------------------------------------
// Request and pixel payload structures, controller/datapath handshake
// structures, divider operation codes and register map.
// ============================================================================
package yrtp_pkg;

    // Field widths fixed by the pixel format.
    localparam int CFG_W  = 13;   // width of frame_width / frame_height
    localparam int SEQ_W  = 32;   // frame sequence number
    localparam int Y_W    = 8;    // one byte of the packed YUYV stream
    localparam int STEP_W = 6;    // divider step counter, holds SEQ_W

    // Pattern constants.
    localparam int LUMA_BASE      = 16;
    localparam int LUMA_SPAN      = 219;
    localparam int LUMA_SPAN_W    = 8;
    localparam int NEUTRAL_CHROMA = 128;
    localparam int PIX_PER_ITEM   = 2;

    // Largest values a 13-bit register can carry for a usable frame.
    localparam int WIDTH_LIMIT  = 8190;
    localparam int HEIGHT_LIMIT = 8191;

    // Parameter defaults.
    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_HEIGHT      = 4096;
    localparam int DEF_SHIFT_PER_FRAME = 8;

    // Register reset values.
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    // Register map.
    localparam int              ADDR_W    = 3;
    localparam logic            REG_WIDTH = 1'b0;
    localparam logic            REG_HEIGHT = 1'b1;
    localparam logic [ADDR_W-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_HEIGHT = 3'd4;

    // Divider operations.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SEQ   = 3'd0;  // sequence mod width
    localparam logic [OP_W-1:0] OP_MUL   = 3'd1;  // scaled remainder mod width
    localparam logic [OP_W-1:0] OP_POS   = 3'd2;  // column plus shift mod width
    localparam logic [OP_W-1:0] OP_LUMA0 = 3'd3;  // even pixel level
    localparam logic [OP_W-1:0] OP_LUMA1 = 3'd4;  // odd pixel level

    typedef struct packed {
        logic             start_frame;
        logic [SEQ_W-1:0] frame_sequence;
    } req_t;

    typedef struct packed {
        logic [Y_W-1:0] luma_first;
        logic [Y_W-1:0] chroma_blue;
        logic [Y_W-1:0] luma_second;
        logic [Y_W-1:0] chroma_red;
        logic           line_end;
        logic           frame_end;
        logic           format_error;
    } pix_t;

    typedef struct packed {
        logic            take;     // latch the accepted request
        logic            restart;  // clear counters and shift
        logic            div_go;   // launch a division
        logic [OP_W-1:0] op;       // which division
        logic            finish;   // load the pixel register, advance counters
    } cmd_t;

    typedef struct packed {
        logic cfg_ok;
        logic start;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/core/yrtp_div.sv =====
// ============================================================================
// yrtp_div - shared restoring divider
// ----------------------------------------------------------------------------
// Takes a left-aligned dividend and retires one bit per cycle. Gives the
// remainder and the low byte of the quotient.
// ============================================================================
module yrtp_div #(
    parameter int REM_W = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [yrtp_pkg::SEQ_W-1:0]   dividend,
    input  logic [yrtp_pkg::STEP_W-1:0]  steps,
    input  logic [REM_W-1:0]             divisor,
    output logic                         done,
    output logic [REM_W-1:0]             rem,
    output logic [yrtp_pkg::Y_W-1:0]     quo
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [yrtp_pkg::STEP_W-1:0]  cnt_reg;
    logic [yrtp_pkg::SEQ_W-1:0]   dvd_reg;
    logic [REM_W-1:0]             dsr_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [yrtp_pkg::Y_W-1:0]     quo_reg;

    logic [REM_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, dvd_reg[yrtp_pkg::SEQ_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == yrtp_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[yrtp_pkg::SEQ_W-2:0], 1'b0};
            quo_reg <= {quo_reg[yrtp_pkg::Y_W-2:0], fits};
            if (fits)
                rem_reg <= REM_W'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[REM_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

    // A finished remainder is always reduced below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/yrtp_dp.sv =====
// ============================================================================
// yrtp_dp - datapath of the YUYV luma ramp generator
// ----------------------------------------------------------------------------
// Holds the line and frame counters, the latched shift, the operands of the
// shared divider and the registered pixel output.
// ============================================================================
module yrtp_dp #(
    parameter int MAX_WIDTH       = yrtp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = yrtp_pkg::DEF_MAX_HEIGHT,
    parameter int SHIFT_PER_FRAME = yrtp_pkg::DEF_SHIFT_PER_FRAME
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  yrtp_pkg::req_t              req,
    input  logic [yrtp_pkg::CFG_W-1:0]  frame_width,
    input  logic [yrtp_pkg::CFG_W-1:0]  frame_height,
    input  yrtp_pkg::cmd_t              cmd,
    output yrtp_pkg::sts_t              sts,
    output yrtp_pkg::pix_t              px
);

    localparam int WCAP  = (MAX_WIDTH < yrtp_pkg::WIDTH_LIMIT) ?
                           MAX_WIDTH : yrtp_pkg::WIDTH_LIMIT;
    localparam int HCAP  = (MAX_HEIGHT < yrtp_pkg::HEIGHT_LIMIT) ?
                           MAX_HEIGHT : yrtp_pkg::HEIGHT_LIMIT;
    localparam int POS_W = $clog2(WCAP + 1);
    localparam int ROW_W = $clog2(HCAP + 1);
    localparam int SHF_W = (SHIFT_PER_FRAME < 1) ? 1 : $clog2(SHIFT_PER_FRAME + 1);
    localparam int MUL_W = POS_W + SHF_W;
    localparam int SUM_W = POS_W + 1;
    localparam int LUM_W = POS_W + yrtp_pkg::LUMA_SPAN_W;
    localparam int DVD_W = yrtp_pkg::SEQ_W;

    logic                        start_reg;
    logic [yrtp_pkg::OP_W-1:0]   op_reg;
    logic [POS_W-1:0]            shift_reg;
    logic [POS_W-1:0]            col_reg;
    logic [ROW_W-1:0]            row_reg;

    logic [DVD_W-1:0]            seq_reg;
    logic [POS_W-1:0]            seqmod_reg;
    logic [POS_W-1:0]            p0_reg;
    logic [yrtp_pkg::Y_W-1:0]    y0_reg;
    logic [yrtp_pkg::Y_W-1:0]    y1_reg;
    yrtp_pkg::pix_t              px_reg;

    logic                        cfg_ok;
    logic [POS_W-1:0]            w_pos;
    logic [MUL_W-1:0]            mul_prod;
    logic [SUM_W-1:0]            pos_sum;
    logic [SUM_W-1:0]            p1_inc;
    logic [POS_W-1:0]            p1;
    logic [LUM_W-1:0]            luma0_prod;
    logic [LUM_W-1:0]            luma1_prod;
    logic [DVD_W-1:0]            dvd;
    logic [yrtp_pkg::STEP_W-1:0] steps;
    logic [POS_W-1:0]            dsr;
    logic                        div_done;
    logic [POS_W-1:0]            div_rem;
    logic [yrtp_pkg::Y_W-1:0]    div_quo;
    logic                        eol;
    logic                        eof;

    assign cfg_ok = !frame_width[0]
                 && (frame_width >= yrtp_pkg::CFG_W'(2))
                 && (32'(frame_width) <= 32'(MAX_WIDTH))
                 && (frame_height != '0)
                 && (32'(frame_height) <= 32'(MAX_HEIGHT));

    // A usable width never exceeds WCAP, so the low bits carry all of it.
    assign w_pos = frame_width[POS_W-1:0];

    assign mul_prod   = MUL_W'(seqmod_reg) * MUL_W'(SHIFT_PER_FRAME);
    assign pos_sum    = SUM_W'(col_reg) + SUM_W'(shift_reg);
    assign p1_inc     = SUM_W'(p0_reg) + SUM_W'(1);
    assign p1         = (p1_inc == SUM_W'(w_pos)) ? '0 : p1_inc[POS_W-1:0];
    assign luma0_prod = LUM_W'(p0_reg) * LUM_W'(yrtp_pkg::LUMA_SPAN);
    assign luma1_prod = LUM_W'(p1) * LUM_W'(yrtp_pkg::LUMA_SPAN);

    // Operands are left-aligned so the divider only walks the bits that matter.
    always_comb
    begin
        dvd   = seq_reg;
        steps = yrtp_pkg::STEP_W'(DVD_W);
        dsr   = w_pos;
        case (cmd.op)
            yrtp_pkg::OP_SEQ:
            begin
                dvd   = seq_reg;
                steps = yrtp_pkg::STEP_W'(DVD_W);
            end
            yrtp_pkg::OP_MUL:
            begin
                dvd   = DVD_W'(mul_prod) << (DVD_W - MUL_W);
                steps = yrtp_pkg::STEP_W'(MUL_W);
            end
            yrtp_pkg::OP_POS:
            begin
                dvd   = DVD_W'(pos_sum) << (DVD_W - SUM_W);
                steps = yrtp_pkg::STEP_W'(SUM_W);
            end
            yrtp_pkg::OP_LUMA0:
            begin
                dvd   = DVD_W'(luma0_prod) << (DVD_W - LUM_W);
                steps = yrtp_pkg::STEP_W'(LUM_W);
                dsr   = w_pos - POS_W'(1);
            end
            yrtp_pkg::OP_LUMA1:
            begin
                dvd   = DVD_W'(luma1_prod) << (DVD_W - LUM_W);
                steps = yrtp_pkg::STEP_W'(LUM_W);
                dsr   = w_pos - POS_W'(1);
            end
            default:
            begin
                dvd   = seq_reg;
                steps = yrtp_pkg::STEP_W'(DVD_W);
            end
        endcase
    end

    yrtp_div #(
        .REM_W (POS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (dvd),
        .steps    (steps),
        .divisor  (dsr),
        .done     (div_done),
        .rem      (div_rem),
        .quo      (div_quo)
    );

    // Counters may sit beyond a shrunken frame, hence the inequalities.
    assign eol = (32'(col_reg) + 32'(yrtp_pkg::PIX_PER_ITEM)) >= 32'(frame_width);
    assign eof = eol && ((32'(row_reg) + 32'd1) >= 32'(frame_height));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
            op_reg    <= yrtp_pkg::OP_SEQ;
            shift_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            if (cmd.take)
                start_reg <= req.start_frame;
            if (cmd.div_go)
                op_reg <= cmd.op;
            if (cmd.restart)
            begin
                shift_reg <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
            end
            if (div_done && (op_reg == yrtp_pkg::OP_MUL))
                shift_reg <= div_rem;
            if (cmd.finish && cfg_ok)
            begin
                if (eof)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (eol)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(yrtp_pkg::PIX_PER_ITEM);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            seq_reg <= req.frame_sequence;
        if (div_done)
        begin
            case (op_reg)
                yrtp_pkg::OP_SEQ:   seqmod_reg <= div_rem;
                yrtp_pkg::OP_POS:   p0_reg     <= div_rem;
                yrtp_pkg::OP_LUMA0: y0_reg <= yrtp_pkg::Y_W'(yrtp_pkg::LUMA_BASE) + div_quo;
                yrtp_pkg::OP_LUMA1: y1_reg <= yrtp_pkg::Y_W'(yrtp_pkg::LUMA_BASE) + div_quo;
                default:            ;
            endcase
        end
        if (cmd.finish)
        begin
            if (cfg_ok)
            begin
                px_reg.luma_first   <= y0_reg;
                px_reg.chroma_blue  <= yrtp_pkg::Y_W'(yrtp_pkg::NEUTRAL_CHROMA);
                px_reg.luma_second  <= y1_reg;
                px_reg.chroma_red   <= yrtp_pkg::Y_W'(yrtp_pkg::NEUTRAL_CHROMA);
                px_reg.line_end     <= eol;
                px_reg.frame_end    <= eof;
                px_reg.format_error <= 1'b0;
            end
            else
            begin
                px_reg.luma_first   <= '0;
                px_reg.chroma_blue  <= '0;
                px_reg.luma_second  <= '0;
                px_reg.chroma_red   <= '0;
                px_reg.line_end     <= 1'b0;
                px_reg.frame_end    <= 1'b0;
                px_reg.format_error <= 1'b1;
            end
        end
    end

    assign sts.cfg_ok   = cfg_ok;
    assign sts.start    = start_reg;
    assign sts.div_done = div_done;
    assign px           = px_reg;

    // A good pixel always carries levels inside the video range.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (px_reg.format_error
                     || (px_reg.luma_first >= 8'd16 && px_reg.luma_first <= 8'd235
                      && px_reg.luma_second >= 8'd16 && px_reg.luma_second <= 8'd235)))
        else $error("luma outside the video range");

    // The end of a frame is always also the end of a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (!px_reg.frame_end || px_reg.line_end))
        else $error("frame end without line end");

endmodule

// ===== rtl/core/yrtp_ctrl.sv =====
// ============================================================================
// yrtp_ctrl - sequencer of the YUYV luma ramp generator
// ----------------------------------------------------------------------------
// Walks one request through its divisions and hands the finished pixel pair
// to the output register.
// ============================================================================
module yrtp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            px_valid,
    input  logic            px_stall,
    input  yrtp_pkg::sts_t  sts,
    output yrtp_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_SEQ    = 4'd2;
    localparam logic [3:0] ST_SEQ_W  = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_MUL_W  = 4'd5;
    localparam logic [3:0] ST_POS    = 4'd6;
    localparam logic [3:0] ST_POS_W  = 4'd7;
    localparam logic [3:0] ST_LUM0   = 4'd8;
    localparam logic [3:0] ST_LUM0_W = 4'd9;
    localparam logic [3:0] ST_LUM1   = 4'd10;
    localparam logic [3:0] ST_LUM1_W = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       px_valid_reg;
    logic       px_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = yrtp_pkg::OP_SEQ;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.restart = sts.start;
                if (!sts.cfg_ok)
                    state_next = ST_FIN;
                else if (sts.start)
                    state_next = ST_SEQ;
                else
                    state_next = ST_POS;
            end
            ST_SEQ:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = yrtp_pkg::OP_SEQ;
                state_next = ST_SEQ_W;
            end
            ST_SEQ_W:
            begin
                if (sts.div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = yrtp_pkg::OP_MUL;
                state_next = ST_MUL_W;
            end
            ST_MUL_W:
            begin
                if (sts.div_done)
                    state_next = ST_POS;
            end
            ST_POS:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = yrtp_pkg::OP_POS;
                state_next = ST_POS_W;
            end
            ST_POS_W:
            begin
                if (sts.div_done)
                    state_next = ST_LUM0;
            end
            ST_LUM0:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = yrtp_pkg::OP_LUMA0;
                state_next = ST_LUM0_W;
            end
            ST_LUM0_W:
            begin
                if (sts.div_done)
                    state_next = ST_LUM1;
            end
            ST_LUM1:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = yrtp_pkg::OP_LUMA1;
                state_next = ST_LUM1_W;
            end
            ST_LUM1_W:
            begin
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!px_valid_reg || !px_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            px_valid_next = 1'b1;
        else if (px_valid_reg && !px_stall)
            px_valid_next = 1'b0;
        else
            px_valid_next = px_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            px_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            px_valid_reg <= px_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign px_valid  = px_valid_reg;

    // The divider only reports back while a division is being awaited.
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_SEQ_W || state_reg == ST_MUL_W
                       || state_reg == ST_POS_W || state_reg == ST_LUM0_W
                       || state_reg == ST_LUM1_W))
        else $error("divider completion outside a wait state");

    // A new pixel only appears as the sequencer leaves its final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(px_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("pixel valid raised outside the finish state");

endmodule

// ===== rtl/core/yuyv_ramp_test_pattern.sv =====
// ============================================================================
// yuyv_ramp_test_pattern - YUYV horizontal luma ramp test pattern source
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   req     | in        | req_valid / req_stall  | start_frame, frame_sequence
//   px      | out       | px_valid / px_stall    | Y0, U, Y1, V, ends, error
//   apb     | in/out    | psel, penable, pready  | frame_width, frame_height
//
// Each request runs its divisions one after another on one shared bit-serial
// divider, which retires a bit a cycle, for the position and the two luma
// levels. A request carrying start_frame first adds two divisions for the
// shift: the sequence mod width, then the scaled remainder mod width.
// With an unusable configuration a request skips the divisions entirely.
// Reset brings back 640 x 480, zero counters and zero shift; no clearing pass.
// A stalled pixel sits in the output register while the next request is
// already being worked on; only the final hand-over waits for it.
// ============================================================================
module yuyv_ramp_test_pattern #(
    parameter int MAX_WIDTH       = yrtp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = yrtp_pkg::DEF_MAX_HEIGHT,
    parameter int SHIFT_PER_FRAME = yrtp_pkg::DEF_SHIFT_PER_FRAME
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  yrtp_pkg::req_t                req,

    output logic                          px_valid,
    input  logic                          px_stall,
    output yrtp_pkg::pix_t                px,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [yrtp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [yrtp_pkg::CFG_W-1:0] frame_width_reg;
    logic [yrtp_pkg::CFG_W-1:0] frame_height_reg;

    yrtp_pkg::cmd_t cmd;
    yrtp_pkg::sts_t sts;

    // The bus never waits; a write lands on the access cycle.
    assign pready = 1'b1;

    // Registers decoded by word. Users must change frame geometry only with no
    // request in flight, so the datapath sees it constant; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= yrtp_pkg::RESET_WIDTH;
            frame_height_reg <= yrtp_pkg::RESET_HEIGHT;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                yrtp_pkg::REG_WIDTH:  frame_width_reg  <= pwdata[yrtp_pkg::CFG_W-1:0];
                yrtp_pkg::REG_HEIGHT: frame_height_reg <= pwdata[yrtp_pkg::CFG_W-1:0];
                default:              ;
            endcase
        end
    end

    // Read-back is exact-address; anything unaligned returns zero.
    always_comb
    begin
        unique case (paddr)
            yrtp_pkg::ADDR_WIDTH:  prdata = 32'(frame_width_reg);
            yrtp_pkg::ADDR_HEIGHT: prdata = 32'(frame_height_reg);
            default:               prdata = '0;
        endcase
    end

    // The sequencer owns the request handshake and the pixel valid flag.
    yrtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .px_valid  (px_valid),
        .px_stall  (px_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Counters, shift, divider and the pixel register live in the datapath.
    yrtp_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .SHIFT_PER_FRAME (SHIFT_PER_FRAME)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cmd          (cmd),
        .sts          (sts),
        .px           (px)
    );

endmodule

// ===== tb/sv/tb_yuyv_ramp_test_pattern.sv =====
// ============================================================================
// tb_yuyv_ramp_test_pattern - self-checking bench for the YUYV ramp source
// ----------------------------------------------------------------------------
// Drives macropixel requests and APB writes of frame width and height. It
// predicts every pixel from its own copy of the counters, the latched shift
// and the frame size, then compares each delivered pixel field by field.
// Sender gaps and receiver stalls vary over the run, with one long receiver
// hold-off.
// ============================================================================
`timescale 1ns / 1ps

class ramp_checker;
    logic [yrtp_pkg::CFG_W-1:0] width_reg;
    logic [yrtp_pkg::CFG_W-1:0] height_reg;
    logic [11:0]                column;
    logic [11:0]                row;
    logic [11:0]                shift;
    yrtp_pkg::pix_t             pending_pixels[$];
    int unsigned                mismatches;

    function new();
        width_reg  = yrtp_pkg::RESET_WIDTH;
        height_reg = yrtp_pkg::RESET_HEIGHT;
        column     = '0;
        row        = '0;
        shift      = '0;
        mismatches = 0;
    endfunction

    function void write_register(logic sel, logic [31:0] data);
        if (sel == yrtp_pkg::REG_WIDTH)
            width_reg = data[yrtp_pkg::CFG_W-1:0];
        else
            height_reg = data[yrtp_pkg::CFG_W-1:0];
    endfunction

    function int unsigned luma_at(int unsigned pos, int unsigned w);
        return yrtp_pkg::LUMA_BASE + (pos * yrtp_pkg::LUMA_SPAN) / (w - 1);
    endfunction

    // Works out one macropixel and advances the counters as the block does.
    function yrtp_pkg::pix_t ramp_pixel(yrtp_pkg::req_t r);
        yrtp_pkg::pix_t p;
        bit             usable;
        int unsigned    w;
        int unsigned    h;
        int unsigned    p0;
        int unsigned    p1;
        bit             eol;
        bit             eof;
        w = width_reg;
        h = height_reg;
        usable = (w % 2 == 0) && (w >= 2) && (w <= yrtp_pkg::DEF_MAX_WIDTH) &&
                 (h >= 1) && (h <= yrtp_pkg::DEF_MAX_HEIGHT);
        if (r.start_frame) begin
            column = '0;
            row    = '0;
            shift  = usable ?
                     12'(((r.frame_sequence % w) * yrtp_pkg::DEF_SHIFT_PER_FRAME) % w)
                   : 12'd0;
        end
        p = '0;
        if (!usable) begin
            p.format_error = 1'b1;
            return p;
        end
        p0  = ((column % w) + (shift % w)) % w;
        p1  = (p0 + 1) % w;
        eol = (column + yrtp_pkg::PIX_PER_ITEM) >= w;
        eof = eol && ((row + 1) >= h);
        p.luma_first  = 8'(luma_at(p0, w));
        p.chroma_blue = 8'(yrtp_pkg::NEUTRAL_CHROMA);
        p.luma_second = 8'(luma_at(p1, w));
        p.chroma_red  = 8'(yrtp_pkg::NEUTRAL_CHROMA);
        p.line_end    = eol;
        p.frame_end   = eof;
        if (eof) begin
            column = '0;
            row    = '0;
        end else if (eol) begin
            column = '0;
            row    = row + 12'd1;
        end else begin
            column = column + 12'(yrtp_pkg::PIX_PER_ITEM);
        end
        return p;
    endfunction

    function void note_request(yrtp_pkg::req_t r);
        pending_pixels.push_back(ramp_pixel(r));
    endfunction

    function int pending_count();
        return pending_pixels.size();
    endfunction

    task report(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_pixel(yrtp_pkg::pix_t got);
        yrtp_pkg::pix_t want;
        if (pending_pixels.size() == 0) begin
            report("pixel delivered while none was outstanding");
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("luma_first", got.luma_first, want.luma_first);
        compare_field("chroma_blue", got.chroma_blue, want.chroma_blue);
        compare_field("luma_second", got.luma_second, want.luma_second);
        compare_field("chroma_red", got.chroma_red, want.chroma_red);
        compare_field("line_end", got.line_end, want.line_end);
        compare_field("frame_end", got.frame_end, want.frame_end);
        compare_field("format_error", got.format_error, want.format_error);
    endtask

    task finish_check();
        if (pending_pixels.size() != 0)
            report($sformatf("%0d pixels never delivered", pending_pixels.size()));
    endtask
endclass

module tb_yuyv_ramp_test_pattern;

    // The drain wait is set well beyond the slowest request (one with
    // start_frame), and the quiet-cycle limit beyond that and beyond the
    // long receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 250;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_ITEMS    = 1000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    yrtp_pkg::req_t              req       = '0;
    logic                        px_valid;
    logic                        px_stall  = 1'b0;
    yrtp_pkg::pix_t              px;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [yrtp_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    // Hold-offs asked for by the stimulus and those already served.
    int unsigned hold_off_req   = 0;
    int unsigned hold_off_seen  = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned random_sent    = 0;
    logic [31:0] frame_number;
    ramp_checker ramp_check;

    yuyv_ramp_test_pattern u_dut (.*);

    always #10 clk = ~clk;

    // Every delivered pixel is compared against the oldest prediction. All
    // sampling happens at the rising edge, before any register updates land.
    always @(posedge clk) begin
        if (rst_n && px_valid && !px_stall)
            ramp_check.check_pixel(px);
    end

    // The receiver stalls at random, or on request holds off for a long,
    // counted stretch so that the block fills up and back-pressures requests.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen = hold_off_req;
                px_stall     <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                px_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: any accepted request, pixel or register write counts as
    // progress. A long run of cycles without any of them ends the run.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (px_valid && !px_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("FAIL yuyv_ramp_test_pattern");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Frame numbers mostly count up, as a camera pipeline would number its
    // frames, with the occasional jump and the two extremes mixed in.
    function automatic logic [31:0] next_sequence();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom();
            default: begin
                frame_number = frame_number + 32'd1;
                return frame_number;
            end
        endcase
    endfunction

    // Offers one request and returns at the edge where it is accepted. Valid
    // is only lowered when a gap is taken, so back-to-back requests keep it
    // high without a second assignment in the same step.
    task automatic send_request(input logic start, input logic [31:0] seq_no);
        yrtp_pkg::req_t r;
        r.start_frame    = start;
        r.frame_sequence = seq_no;
        while ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        ramp_check.note_request(r);
    endtask

    // Stops offering requests and waits until every predicted pixel is back.
    task automatic wait_for_pixels();
        req_valid <= 1'b0;
        @(posedge clk);
        while (ramp_check.pending_count() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. The upper data
    // bits carry noise, which the block must ignore.
    task automatic write_register(input logic sel,
                                  input logic [yrtp_pkg::CFG_W-1:0] value);
        logic [31:0] data;
        data                     = $urandom();
        data[yrtp_pkg::CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (sel == yrtp_pkg::REG_WIDTH) ? yrtp_pkg::ADDR_WIDTH
                                                : yrtp_pkg::ADDR_HEIGHT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        ramp_check.write_register(sel, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // The frame size is only changed once the block has handed back all its
    // pixels, so nothing in flight sees a half-applied setting.
    task automatic configure(input int w, input int h);
        wait_for_pixels();
        write_register(yrtp_pkg::REG_WIDTH, w[yrtp_pkg::CFG_W-1:0]);
        write_register(yrtp_pkg::REG_HEIGHT, h[yrtp_pkg::CFG_W-1:0]);
    endtask

    // One random phase: pick a frame size, then stream requests, mostly with
    // start_frame at the frame boundaries, plus a little noise. The first
    // request of a phase sometimes carries on with the old counters, which
    // may then lie beyond a smaller frame.
    task automatic random_phase();
        int w;
        int h;
        int n;
        int frame_len;
        bit start;
        case ($urandom_range(9))
            0: begin
                // Unusable settings: odd, zero or oversized width, or a bad
                // height.
                case ($urandom_range(4))
                    0: begin
                        w = 2 * $urandom_range(0, 4095) + 1;
                        h = $urandom_range(1, 16);
                    end
                    1: begin
                        w = 0;
                        h = $urandom_range(1, 16);
                    end
                    2: begin
                        w = 2 * $urandom_range(yrtp_pkg::DEF_MAX_WIDTH / 2 + 1, 4095);
                        h = $urandom_range(1, 16);
                    end
                    3: begin
                        w = 2 * $urandom_range(1, 16);
                        h = 0;
                    end
                    default: begin
                        w = 2 * $urandom_range(1, 16);
                        h = $urandom_range(yrtp_pkg::DEF_MAX_HEIGHT + 1,
                                           yrtp_pkg::HEIGHT_LIMIT);
                    end
                endcase
                frame_len = 8;
                n = $urandom_range(3, 10);
            end
            1: begin
                w = yrtp_pkg::DEF_MAX_WIDTH;
                h = $urandom_range(1) ? yrtp_pkg::DEF_MAX_HEIGHT
                                      : $urandom_range(1, yrtp_pkg::DEF_MAX_HEIGHT);
                frame_len = (w / 2) * h;
                n = $urandom_range(5, 40);
            end
            2: begin
                w = 2 * $urandom_range(1, yrtp_pkg::DEF_MAX_WIDTH / 2);
                h = 1;
                frame_len = w / 2;
                n = $urandom_range(5, 40);
            end
            default: begin
                // Small frames, so that line and frame ends come often.
                w = 2 * $urandom_range(1, 16);
                h = $urandom_range(1, 6);
                frame_len = (w / 2) * h;
                n = frame_len * $urandom_range(1, 3) + $urandom_range(0, 3);
                if (n > 120)
                    n = 120;
            end
        endcase
        configure(w, h);
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                start = ($urandom_range(99) < 70);
            else if (i % frame_len == 0)
                start = ($urandom_range(99) < 90);
            else
                start = ($urandom_range(99) < 3);
            // Idling regime: receiver-heavy stalls, then sender-heavy gaps with the
            // rates swapped round, then a final stretch at full rate.
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_gap_pct   = 35;
                recv_stall_pct = 76;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 76;
                recv_stall_pct = 35;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            send_request(start, start ? next_sequence() : $urandom());
            random_sent++;
        end
    endtask

    initial begin
        ramp_check   = new();
        frame_number = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting of 640 x 480: start from the origin with sequence
        // zero, run on, then restart with the largest sequence number.
        send_request(1'b1, 32'd0);
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF);

        // Narrowest and shortest frame: every macropixel ends the frame, and
        // without start_frame the counters simply wrap.
        configure(2, 1);
        send_request(1'b1, 32'd1);
        send_request(1'b0, 32'h5A5A_A5A5);
        send_request(1'b0, 32'hA5A5_5A5A);

        // A 6 x 2 frame, run one frame and a bit past its end so that the
        // wrap keeps the old shift and the column ends up part-way along.
        configure(6, 2);
        send_request(1'b1, 32'd5);
        repeat (7) send_request(1'b0, $urandom());

        // Shrink the width below the column counter without a restart: the
        // line and frame end at once.
        configure(4, 1);
        repeat (2) send_request(1'b0, $urandom());

        // Unusable settings: the pixels come back zeroed with the error flag,
        // and a start_frame still clears the counters.
        configure(7, 2);
        send_request(1'b0, $urandom());
        send_request(1'b1, $urandom());
        configure(0, 1);
        send_request(1'b1, $urandom());
        configure(yrtp_pkg::DEF_MAX_WIDTH, 0);
        send_request(1'b0, $urandom());

        // Largest usable frame.
        configure(yrtp_pkg::DEF_MAX_WIDTH, yrtp_pkg::DEF_MAX_HEIGHT);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'd0);

        // Register maxima, both out of range.
        configure(yrtp_pkg::WIDTH_LIMIT, yrtp_pkg::HEIGHT_LIMIT);
        send_request(1'b1, $urandom());

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering, then the sender waits for everything back.
        configure(16, 4);
        hold_off_req <= hold_off_req + 1;
        for (int i = 0; i < 20; i++)
            send_request(i == 0, next_sequence());
        wait_for_pixels();

        while (random_sent < RANDOM_ITEMS)
            random_phase();

        wait_for_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);
        ramp_check.finish_check();
        if (ramp_check.mismatches == 0)
            $display("PASS yuyv_ramp_test_pattern");
        else
            $display("FAIL yuyv_ramp_test_pattern");
        $finish;
    end

endmodule
